FILE: rtl/mips_integer_execute_unit_assert.svh
// Assertion macros for the MIPS integer execute unit
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MIEU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mieu assertion failed");
`define MIEU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mieu assertion failed");
`else
`define MIEU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MIEU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/mieu_pkg.sv
`default_nettype none
package mieu_pkg;
  localparam logic [31:0] VecBoot   = 32'hbfc00180;
  localparam logic [31:0] VecNormal = 32'h80000080;
  localparam logic [31:0] ResetPc   = 32'hbfc00000;
  localparam logic [31:0] RegInit   = 32'hdeadbeef;
  localparam int unsigned BevBit    = 22;

  typedef enum logic [2:0] {
    TK_OVF = 3'd0, TK_SYS = 3'd1, TK_BRK = 3'd2, TK_RI = 3'd3, TK_CPU = 3'd4
  } trap_kind_e;

  typedef struct packed {
    logic [31:0] exec_pc;
    logic [31:0] fetch_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        took_branch;
    logic        trapped;
    logic [2:0]  trap_kind;
    logic        unhandled;
  } result_t;

  function automatic logic [4:0] exc_code(input trap_kind_e k);
    case (k)
      TK_OVF:  exc_code = 5'd12;
      TK_SYS:  exc_code = 5'd8;
      TK_BRK:  exc_code = 5'd9;
      TK_RI:   exc_code = 5'd10;
      TK_CPU:  exc_code = 5'd11;
      default: exc_code = 5'd12;
    endcase
  endfunction
endpackage
`default_nettype wire

FILE: rtl/mieu_decode.sv
`default_nettype none
// Combinational execute of one instruction against operand values and CP0 state
module mieu_decode (
  input  var logic [31:0]  instr_i,
  input  var logic [31:0]  a_i,
  input  var logic [31:0]  b_i,
  input  var logic [31:0]  exec_pc_i,
  input  var logic [31:0]  status_i,
  input  var logic [31:0]  cause_i,
  input  var logic [31:0]  epc_i,
  output logic             wr_o,
  output logic [4:0]       widx_o,
  output logic [31:0]      wval_o,
  output logic             took_o,
  output logic [31:0]      target_o,
  output logic             trap_o,
  output mieu_pkg::trap_kind_e kind_o,
  output logic [1:0]       cop_o,
  output logic             unh_o,
  output logic             st_wr_o,
  output logic [31:0]      st_val_o,
  output logic             ca_wr_o
);
  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd;
  logic [15:0] imm;
  logic [31:0] simm, sum, dif, sumi, btarget;

  always_comb begin
    op = instr_i[31:26]; rs = instr_i[25:21]; rt = instr_i[20:16];
    rd = instr_i[15:11]; fn = instr_i[5:0]; imm = instr_i[15:0];
    simm = {{16{imm[15]}}, imm};
    sum = a_i + b_i; dif = a_i - b_i; sumi = a_i + simm;
    btarget = exec_pc_i + 32'd4 + {simm[29:0], 2'b00};
    wr_o = 1'b0; widx_o = rd; wval_o = '0; took_o = 1'b0; target_o = a_i;
    trap_o = 1'b0; kind_o = mieu_pkg::TK_OVF; cop_o = 2'd0; unh_o = 1'b0;
    st_wr_o = 1'b0; st_val_o = b_i; ca_wr_o = 1'b0;
    if (op == 6'h00) begin
      case (fn) inside
        6'h00, 6'h02, 6'h03, 6'h04, 6'h06, 6'h07, [6'h10:6'h13], [6'h18:6'h1B]:
          unh_o = 1'b1;
        6'h08: took_o = 1'b1;
        6'h09: begin took_o = 1'b1; wr_o = 1'b1; wval_o = exec_pc_i + 32'd8; end
        6'h0C: begin trap_o = 1'b1; kind_o = mieu_pkg::TK_SYS; end
        6'h0D: begin trap_o = 1'b1; kind_o = mieu_pkg::TK_BRK; end
        6'h20: begin
          if ((a_i[31] ^ sum[31]) & (b_i[31] ^ sum[31])) trap_o = 1'b1;
          else begin wr_o = 1'b1; wval_o = sum; end
        end
        6'h21: begin wr_o = 1'b1; wval_o = sum; end
        6'h22: begin
          if ((a_i[31] ^ b_i[31]) & (a_i[31] ^ dif[31])) trap_o = 1'b1;
          else begin wr_o = 1'b1; wval_o = dif; end
        end
        6'h23: begin wr_o = 1'b1; wval_o = dif; end
        6'h24: begin wr_o = 1'b1; wval_o = a_i & b_i; end
        6'h25: begin wr_o = 1'b1; wval_o = a_i | b_i; end
        6'h26: begin wr_o = 1'b1; wval_o = a_i ^ b_i; end
        6'h27: begin wr_o = 1'b1; wval_o = ~(a_i | b_i); end
        6'h2A: begin wr_o = 1'b1; wval_o = {31'd0, $signed(a_i) < $signed(b_i)}; end
        6'h2B: begin wr_o = 1'b1; wval_o = {31'd0, a_i < b_i}; end
        default: begin trap_o = 1'b1; kind_o = mieu_pkg::TK_RI; end
      endcase
    end else begin
      widx_o = rt;
      target_o = btarget;
      case (op) inside
        6'h02, 6'h03: begin
          took_o = 1'b1;
          target_o = {exec_pc_i[31:28] + {3'd0, &exec_pc_i[27:2]}, instr_i[25:0], 2'b00};
          if (op == 6'h03) begin
            wr_o = 1'b1; widx_o = 5'd31; wval_o = exec_pc_i + 32'd8;
          end
        end
        6'h04: took_o = (a_i == b_i);
        6'h05: took_o = (a_i != b_i);
        6'h06: took_o = (a_i == '0) || a_i[31];
        6'h07: took_o = (a_i != '0) && !a_i[31];
        6'h08: begin
          if ((a_i[31] ^ sumi[31]) & (simm[31] ^ sumi[31])) trap_o = 1'b1;
          else begin wr_o = 1'b1; wval_o = sumi; end
        end
        6'h09: begin wr_o = 1'b1; wval_o = sumi; end
        6'h0A: begin wr_o = 1'b1; wval_o = {31'd0, $signed(a_i) < $signed(simm)}; end
        6'h0B: begin wr_o = 1'b1; wval_o = {31'd0, a_i < simm}; end
        6'h0C: begin wr_o = 1'b1; wval_o = a_i & {16'd0, imm}; end
        6'h0D: begin wr_o = 1'b1; wval_o = a_i | {16'd0, imm}; end
        6'h0E: begin wr_o = 1'b1; wval_o = a_i ^ {16'd0, imm}; end
        6'h0F: begin wr_o = 1'b1; wval_o = {imm, 16'd0}; end
        6'h10: begin
          if (rs == 5'h00) begin
            wr_o = 1'b1;
            case (rd)
              5'd12:   wval_o = status_i;
              5'd13:   wval_o = cause_i;
              5'd14:   wval_o = epc_i;
              default: wval_o = '0;
            endcase
          end else if (rs == 5'h04) begin
            st_wr_o = (rd == 5'd12);
            ca_wr_o = (rd == 5'd13);
          end else if (rs == 5'h10 && fn == 6'h10) begin
            st_wr_o = 1'b1;
            st_val_o = {status_i[31:4], status_i[5:2]};
          end else begin
            trap_o = 1'b1; kind_o = mieu_pkg::TK_CPU;
          end
        end
        6'h11: begin trap_o = 1'b1; kind_o = mieu_pkg::TK_CPU; cop_o = 2'd1; end
        6'h13: begin trap_o = 1'b1; kind_o = mieu_pkg::TK_CPU; cop_o = 2'd3; end
        6'h12, [6'h20:6'h26], [6'h28:6'h2B], 6'h2E, [6'h30:6'h33], [6'h38:6'h3B]:
          unh_o = 1'b1;
        default: begin trap_o = 1'b1; kind_o = mieu_pkg::TK_RI; end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mips_integer_execute_unit.sv
`default_nettype none
// Channel  | Dir | Payload
// s_axis   | in  | tdata[31:0] instr_word
// m_axis   | out | tdata[135:0] see port comment
// One instruction per cycle unless m_axis back-pressure holds the result: decode,
// register read and execute are one combinational pass from the architectural state;
// the result register holds the outcome, valid in the cycle after acceptance.
// A request is taken whenever the result register is empty or being drained.
// Reset: PC 0xbfc00000, registers read 0xdeadbeef via per-register valid bits.
module mips_integer_execute_unit (
  input  var logic         clk_i,
  input  var logic         rst_ni,
  input  var logic         s_axis_tvalid,
  output logic             s_axis_tready,
  input  var logic [31:0]  s_axis_tdata,   // [31:0] instr_word
  output logic             m_axis_tvalid,
  input  var logic         m_axis_tready,
  // [31:0] exec_pc, [63:32] fetch_pc, [64] reg_write, [69:65] reg_index,
  // [101:70] reg_value, [102] took_branch, [103] trapped, [106:104] trap_kind,
  // [107] unhandled, [135:108] zero
  output logic [135:0]     m_axis_tdata
);
  `include "mips_integer_execute_unit_assert.svh"

  logic [31:0] gpr_q [32];
  logic [31:0] gpr_vld_q;
  logic [31:0] pc_q, npc_q, status_q, cause_q, epc_q;
  logic        bpend_q, out_vld_q;
  mieu_pkg::result_t res_q, res_d;

  logic [31:0] a, b, wval, target, st_val;
  logic [4:0]  widx;
  logic        wr, took, trap, unh, st_wr, ca_wr, acc, do_wr;
  logic [1:0]  cop;
  mieu_pkg::trap_kind_e kind;
  logic [31:0] vec, new_status;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    a = (s_axis_tdata[25:21] == 5'd0) ? '0 :
        gpr_vld_q[s_axis_tdata[25:21]] ? gpr_q[s_axis_tdata[25:21]] : mieu_pkg::RegInit;
    b = (s_axis_tdata[20:16] == 5'd0) ? '0 :
        gpr_vld_q[s_axis_tdata[20:16]] ? gpr_q[s_axis_tdata[20:16]] : mieu_pkg::RegInit;
  end

  mieu_decode u_dec (
    .instr_i(s_axis_tdata), .a_i(a), .b_i(b), .exec_pc_i(pc_q),
    .status_i(status_q), .cause_i(cause_q), .epc_i(epc_q),
    .wr_o(wr), .widx_o(widx), .wval_o(wval), .took_o(took), .target_o(target),
    .trap_o(trap), .kind_o(kind), .cop_o(cop), .unh_o(unh),
    .st_wr_o(st_wr), .st_val_o(st_val), .ca_wr_o(ca_wr)
  );

  always_comb begin
    do_wr = wr && !trap && (widx != 5'd0);
    new_status = {status_q[31:6], status_q[3:0], 2'b00};
    vec = new_status[mieu_pkg::BevBit] ? mieu_pkg::VecBoot : mieu_pkg::VecNormal;
    res_d.exec_pc = pc_q;
    res_d.fetch_pc = trap ? vec : npc_q;
    res_d.reg_write = do_wr;
    res_d.reg_index = do_wr ? widx : '0;
    res_d.reg_value = do_wr ? wval : '0;
    res_d.took_branch = took && !trap;
    res_d.trapped = trap;
    res_d.trap_kind = trap ? kind : '0;
    res_d.unhandled = unh;
  end

  always_ff @(posedge clk_i) begin
    if (acc && do_wr) gpr_q[widx] <= wval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_vld_q <= '0; pc_q <= mieu_pkg::ResetPc; npc_q <= mieu_pkg::ResetPc + 32'd4;
      bpend_q <= 1'b0; status_q <= '0; cause_q <= '0;
      epc_q <= '0; out_vld_q <= 1'b0; res_q <= '0;
    end else begin
      out_vld_q <= acc || (out_vld_q && !m_axis_tready);
      if (acc) begin
        res_q <= res_d;
        if (do_wr) gpr_vld_q[widx] <= 1'b1;
        if (trap) begin
          // Delay-slot faults report the branch address
          epc_q <= bpend_q ? pc_q - 32'd4 : pc_q;
          cause_q <= {bpend_q, 1'b0, cop, 12'd0, cause_q[15:8], 1'b0,
                      mieu_pkg::exc_code(kind), 2'b00};
          status_q <= new_status;
          pc_q <= vec; npc_q <= vec + 32'd4;
          bpend_q <= 1'b0;
        end else begin
          pc_q <= npc_q;
          npc_q <= took ? target : npc_q + 32'd4;
          bpend_q <= took;
          if (st_wr) status_q <= st_val;
          if (ca_wr) cause_q <= b;
        end
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  // First field in the lowest bits
  assign m_axis_tdata = {28'd0, res_q.unhandled, res_q.trap_kind, res_q.trapped,
                         res_q.took_branch, res_q.reg_value, res_q.reg_index,
                         res_q.reg_write, res_q.fetch_pc, res_q.exec_pc};

  `MIEU_ASSERT_NXT(a_trap_no_wr, clk_i, rst_ni, acc && trap, !res_q.reg_write)
  `MIEU_ASSERT_NXT(a_trap_no_br, clk_i, rst_ni, acc && trap, !res_q.took_branch)
  `MIEU_ASSERT_IMP(a_hold, clk_i, rst_ni, out_vld_q && !m_axis_tready, !s_axis_tready)
endmodule
`default_nettype wire
